>>> sv/brb_pkg.sv
// Shared types and constants for the byte ring buffer with overwrite.
// Used by brb_ctrl, brb_datapath and byte_ring_buffer_overwrite_core.
// No dependencies.
package brb_pkg;

   localparam int STORE_DEPTH_DEF    = 1024;
   localparam int MAX_READ_BURST_DEF = 64;
   localparam int CAP_W              = 11;
   localparam int LEN_W              = 12;
   localparam int DATA_W             = 8;
   localparam int TYPE_W             = 4;
   localparam int CAP_RESET          = 1024;
   localparam int CAP_LIMIT          = 2047;   // upper limit on capacity; a smaller store depth lowers it

   typedef enum logic [TYPE_W-1:0] {
      REQ_CLEAR     = 4'd0,
      REQ_WRITE     = 4'd1,
      REQ_TRY_WRITE = 4'd2,
      REQ_FORCED    = 4'd3,
      REQ_FALLBACK  = 4'd4,
      REQ_READ      = 4'd5,
      REQ_PEEK      = 4'd6,
      REQ_PURGE     = 4'd7,
      REQ_COUNT     = 4'd8
   } req_code_type;

   typedef enum logic [1:0] {
      BK_NONE   = 2'd0,
      BK_WRITE  = 2'd1,
      BK_TRY    = 2'd2,
      BK_FORCED = 2'd3
   } burst_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_ADDR,
      ST_RD_DATA
   } brb_state_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [LEN_W-1:0]  req_len;
      logic [DATA_W-1:0] data_in;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_out;
      logic              data_valid;
      logic [LEN_W-1:0]  moved_count;
      logic              last_result;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic rd_issue;
      logic rd_deliver;
   } brb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic rsp_full;
      logic burst_silent;
      logic read_start;
      logic read_last;
   } brb_status_type;

endpackage

>>> sv/brb_ctrl.sv
// Request sequencer for the byte ring buffer: accepts requests and steps
// multi-byte read/peek bursts through the store. Depends on brb_pkg.
module brb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   input  brb_pkg::brb_status_type status,
   output brb_pkg::brb_cmd_type    cmd
);
   import brb_pkg::*;

   brb_state_type state_ff, state_in;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign out_free = !status.rsp_full || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            // middle bytes of a write burst give no result, so they never wait
            req_ready  = out_free || status.burst_silent;
            cmd.accept = req_valid && req_ready;
            if (cmd.accept && status.read_start) begin
               state_in = ST_RD_ADDR;
            end
         end
         ST_RD_ADDR: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (out_free) begin
               cmd.rd_deliver = 1'b1;
               state_in       = status.read_last ? ST_IDLE : ST_RD_ADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/brb_datapath.sv
// Datapath of the byte ring buffer: byte store, ring indices, burst
// bookkeeping, capacity register and result register. Depends on brb_pkg.
module brb_datapath #(
   parameter int STORE_DEPTH    = brb_pkg::STORE_DEPTH_DEF,
   parameter int MAX_READ_BURST = brb_pkg::MAX_READ_BURST_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  brb_pkg::brb_cmd_type         cmd,
   output brb_pkg::brb_status_type      status,
   input  brb_pkg::req_item_type        req_payload,
   output brb_pkg::rsp_item_type        rsp_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         csr_we,
   input  logic [brb_pkg::CAP_W-1:0]    csr_wdata
);
   import brb_pkg::*;

   localparam int CAP_MAX = (STORE_DEPTH < CAP_LIMIT) ? STORE_DEPTH : CAP_LIMIT;
   localparam int CNT_W   = $clog2(CAP_MAX + 1);
   localparam int EXT_W   = CNT_W + 1;
   localparam int IDX_W   = $clog2(CAP_MAX);
   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int RB_W    = $clog2(MAX_READ_BURST + 1);
   localparam int CAP_RST = (CAP_RESET < CAP_MAX) ? CAP_RESET : CAP_MAX;

   logic [DATA_W-1:0] mem [STORE_DEPTH];
   logic [DATA_W-1:0] mem_q_ff;
   logic              mem_we;

   logic [CNT_W-1:0]  cap_ff, count_ff, count_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in, wr_idx_ff, wr_idx_in, walk_ff, walk_in;
   logic [LEN_W-1:0]  burst_rem_ff, burst_rem_in, burst_skip_ff, burst_skip_in;
   logic [LEN_W-1:0]  burst_acc_ff, burst_acc_in;
   burst_kind_type    burst_kind_ff, burst_kind_in;
   logic [RB_W-1:0]   left_ff, left_in, rb_n_ff, rb_n_in;
   logic              is_read_ff, is_read_in;
   rsp_item_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // request arithmetic
   logic [LEN_W-1:0]  len, cap12, cnt12, space12, rb_max12, rb_lim, rd_n12;
   logic [LEN_W-1:0]  acc_write, acc_try, acc_forced;
   logic [CNT_W-1:0]  space, trim_n;
   logic [RB_W-1:0]   rd_n;
   logic [EXT_W-1:0]  wr_back, rd_fwd;
   logic [IDX_W-1:0]  wr_back_idx, rd_fwd_idx;

   // byte of a write burst
   logic              byte_item, keep;
   burst_kind_type    kind_e;
   logic [LEN_W-1:0]  rem_e, skip_e, acc_e;

   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i,
                                                   input logic [CNT_W-1:0] c);
      logic [EXT_W-1:0] inc;
      inc = EXT_W'(i) + EXT_W'(1);
      return (inc >= EXT_W'(c)) ? '0 : inc[IDX_W-1:0];
   endfunction

   assign len      = req_payload.req_len;
   assign cap12    = LEN_W'(cap_ff);
   assign cnt12    = LEN_W'(count_ff);
   assign space    = cap_ff - count_ff;
   assign space12  = LEN_W'(space);
   assign rb_max12 = LEN_W'(MAX_READ_BURST);

   assign acc_write  = (len < space12) ? len : space12;
   assign acc_try    = (len > space12) ? '0 : len;
   assign acc_forced = (len < cap12) ? len : cap12;

   assign trim_n = (len < cnt12) ? len[CNT_W-1:0] : count_ff;
   assign rb_lim = (len < rb_max12) ? len : rb_max12;
   assign rd_n12 = (rb_lim < cnt12) ? rb_lim : cnt12;
   assign rd_n   = rd_n12[RB_W-1:0];

   // fallback steps the write index back, purge steps the read index forward
   assign wr_back     = EXT_W'(wr_idx_ff) - EXT_W'(trim_n);
   assign wr_back_idx = wr_back[CNT_W] ? IDX_W'(wr_back + EXT_W'(cap_ff))
                                       : wr_back[IDX_W-1:0];
   assign rd_fwd      = EXT_W'(rd_idx_ff) + EXT_W'(trim_n);
   assign rd_fwd_idx  = (rd_fwd >= EXT_W'(cap_ff)) ? IDX_W'(rd_fwd - EXT_W'(cap_ff))
                                                  : rd_fwd[IDX_W-1:0];

   assign status.rsp_full     = rsp_valid_ff;
   assign status.burst_silent = (burst_kind_ff != BK_NONE) && (burst_rem_ff != LEN_W'(1));
   assign status.read_start   = (burst_kind_ff == BK_NONE) && (rd_n != '0) &&
                                ((req_payload.req_type == REQ_READ) ||
                                 (req_payload.req_type == REQ_PEEK));
   assign status.read_last    = (left_ff == RB_W'(1));

   assign rsp_payload = rsp_ff;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      walk_in       = walk_ff;
      burst_rem_in  = burst_rem_ff;
      burst_skip_in = burst_skip_ff;
      burst_acc_in  = burst_acc_ff;
      burst_kind_in = burst_kind_ff;
      left_in       = left_ff;
      rb_n_in       = rb_n_ff;
      is_read_in    = is_read_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_we        = 1'b0;
      byte_item     = 1'b0;
      keep          = 1'b0;
      kind_e        = burst_kind_ff;
      rem_e         = burst_rem_ff;
      skip_e        = burst_skip_ff;
      acc_e         = burst_acc_ff;

      if (cmd.accept) begin
         rsp_in             = '0;
         rsp_in.last_result = 1'b1;
         if (burst_kind_ff != BK_NONE) begin
            byte_item = 1'b1;
            keep      = (burst_kind_ff == BK_FORCED) ? (burst_rem_ff <= burst_acc_ff)
                                                     : (burst_rem_ff > burst_skip_ff);
         end else begin
            unique case (req_payload.req_type) inside
               REQ_WRITE, REQ_TRY_WRITE, REQ_FORCED: begin
                  if (len == '0) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     byte_item = 1'b1;
                     kind_e    = burst_kind_type'(req_payload.req_type[1:0]);
                     rem_e     = len;
                     // the opening byte is kept exactly when the burst keeps anything
                     // at its head
                     if (req_payload.req_type == REQ_WRITE) begin
                        acc_e = acc_write;
                        keep  = (space != '0);
                     end else if (req_payload.req_type == REQ_TRY_WRITE) begin
                        acc_e = acc_try;
                        keep  = (len <= space12);
                     end else begin
                        acc_e = acc_forced;
                        keep  = (len <= cap12);
                     end
                     skip_e = len - acc_e;
                  end
               end
               REQ_CLEAR: begin
                  rd_idx_in    = '0;
                  wr_idx_in    = '0;
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
               end
               REQ_FALLBACK: begin
                  wr_idx_in          = wr_back_idx;
                  count_in           = count_ff - trim_n;
                  rsp_in.moved_count = LEN_W'(trim_n);
                  rsp_valid_in       = 1'b1;
               end
               REQ_PURGE: begin
                  rd_idx_in          = rd_fwd_idx;
                  count_in           = count_ff - trim_n;
                  rsp_in.moved_count = LEN_W'(trim_n);
                  rsp_valid_in       = 1'b1;
               end
               REQ_READ, REQ_PEEK: begin
                  if (rd_n == '0) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     rsp_in       = rsp_ff;
                     walk_in      = rd_idx_ff;
                     left_in      = rd_n;
                     rb_n_in      = rd_n;
                     is_read_in   = (req_payload.req_type == REQ_READ);
                  end
               end
               REQ_COUNT: begin
                  rsp_in.moved_count = cnt12;
                  rsp_valid_in       = 1'b1;
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end

         if (byte_item) begin
            if (keep) begin
               mem_we    = 1'b1;
               wr_idx_in = next_index(wr_idx_ff, cap_ff);
               if (count_ff == cap_ff) begin
                  rd_idx_in = next_index(rd_idx_ff, cap_ff);   // ring full: drop oldest
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            if (rem_e == LEN_W'(1)) begin
               burst_kind_in      = BK_NONE;
               burst_rem_in       = '0;
               burst_skip_in      = '0;
               burst_acc_in       = '0;
               rsp_in.moved_count = acc_e;
               rsp_valid_in       = 1'b1;
            end else begin
               rsp_in        = rsp_ff;
               burst_kind_in = kind_e;
               burst_rem_in  = rem_e - LEN_W'(1);
               burst_skip_in = skip_e;
               burst_acc_in  = acc_e;
            end
         end
      end

      if (cmd.rd_deliver) begin
         rsp_in.data_out    = mem_q_ff;
         rsp_in.data_valid  = 1'b1;
         rsp_in.moved_count = LEN_W'(rb_n_ff);
         rsp_in.last_result = (left_ff == RB_W'(1));
         rsp_valid_in       = 1'b1;
         walk_in            = next_index(walk_ff, cap_ff);
         left_in            = left_ff - RB_W'(1);
         if ((left_ff == RB_W'(1)) && is_read_ff) begin
            rd_idx_in = next_index(walk_ff, cap_ff);
            count_in  = count_ff - CNT_W'(rb_n_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CNT_W'(CAP_RST);
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         wr_idx_ff     <= '0;
         burst_rem_ff  <= '0;
         burst_skip_ff <= '0;
         burst_acc_ff  <= '0;
         burst_kind_ff <= BK_NONE;
         left_ff       <= '0;
         is_read_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (csr_we) begin
         // new capacity empties the ring and drops any open burst
         if (csr_wdata == '0) begin
            cap_ff <= CNT_W'(1);
         end else if (csr_wdata > CAP_W'(CAP_MAX)) begin
            cap_ff <= CNT_W'(CAP_MAX);
         end else begin
            cap_ff <= CNT_W'(csr_wdata);
         end
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         wr_idx_ff     <= '0;
         burst_rem_ff  <= '0;
         burst_skip_ff <= '0;
         burst_acc_ff  <= '0;
         burst_kind_ff <= BK_NONE;
         left_ff       <= '0;
         is_read_ff    <= 1'b0;
         rsp_valid_ff  <= rsp_valid_in;
      end else begin
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         wr_idx_ff     <= wr_idx_in;
         burst_rem_ff  <= burst_rem_in;
         burst_skip_ff <= burst_skip_in;
         burst_acc_ff  <= burst_acc_in;
         burst_kind_ff <= burst_kind_in;
         left_ff       <= left_in;
         is_read_ff    <= is_read_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      rb_n_ff <= rb_n_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ADDR_W'(wr_idx_ff)] <= req_payload.data_in;
      end
      if (cmd.rd_issue) begin
         mem_q_ff <= mem[ADDR_W'(walk_ff)];
      end
   end

endmodule

>>> sv/byte_ring_buffer_overwrite_core.sv
// Byte FIFO in a circular store with overwrite: top level.
// Instantiates brb_ctrl and brb_datapath; depends on brb_pkg.
//
// Usage: requests enter on req_valid/req_ready with a req_item_type payload,
// results leave on rsp_valid/rsp_ready with an rsp_item_type payload.
// A write burst is req_len requests of one byte each; they are taken one per
// cycle unless a waiting result holds them, and only the last one produces a
// result. Clear, fallback, purge, count, zero-length writes and reads or peeks
// of zero bytes give one result, registered as the request is taken. A read
// or peek of n bytes gives n results; each byte passes a store read address
// state, then its registered store data goes into the result register. While
// a read or peek is being delivered no request is taken. A finished result
// waits in the result register; while it waits with rsp_ready low, requests
// wait too, except middle bytes of a write burst, which still go in. Writing
// the capacity register (csr_we/csr_wdata) empties the ring and abandons any
// open burst; write it only when the block is idle. Synchronous reset sets
// capacity to 1024 (limited to the store depth) and empties the ring; store
// contents are not cleared.
module byte_ring_buffer_overwrite_core #(
   parameter int STORE_DEPTH    = brb_pkg::STORE_DEPTH_DEF,
   parameter int MAX_READ_BURST = brb_pkg::MAX_READ_BURST_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  brb_pkg::req_item_type     req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output brb_pkg::rsp_item_type     rsp_payload,
   input  logic                      csr_we,
   input  logic [brb_pkg::CAP_W-1:0] csr_wdata
);
   import brb_pkg::*;

   brb_cmd_type    cmd;
   brb_status_type status;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   brb_datapath #(
      .STORE_DEPTH    (STORE_DEPTH),
      .MAX_READ_BURST (MAX_READ_BURST)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

endmodule
